// ===== rtl/dlr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dlr_pkg;

   // Frame layout: eight Q2.22 samples, packed lane 0 first.
   localparam int LANE_FIELDS = 8;
   localparam int SAMPLE_W    = 24;
   localparam int REQ_DATA_W  = LANE_FIELDS * SAMPLE_W;

   // Q2.22: 1.0 is 2**Q_FRAC.
   localparam int Q_FRAC = 22;

   // Output sample width; the full-scale factor is 2**(OUT_W-1) - 1.
   localparam int OUT_W = 16;

   // Lane sum of up to eight samples and the reciprocal used to average it.
   localparam int SUM_W       = SAMPLE_W + 3;
   localparam int RECIP_W     = 28;
   localparam int RECIP_SHIFT = 27;

   // Configuration registers.
   localparam int COUNT_W    = 4;
   localparam int RATE_W     = 18;
   localparam int CFG_DATA_W = 18;
   localparam int CFG_ADDR_W = 1;

   localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = 1'd0;
   localparam logic [CFG_ADDR_W-1:0] REG_INPUT_RATE    = 1'd1;

   localparam logic [RATE_W-1:0] RATE_MIN = 18'd8000;
   localparam logic [RATE_W-1:0] RATE_MAX = 18'd192000;

   // At most this many results leave for one frame.
   localparam int RESULT_CAP = 4;
   localparam int CNT_W      = $clog2(RESULT_CAP + 1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SAMPLE_W:0]   pair_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic signed [OUT_W-1:0]    out_sample_type;

   // floor(2**27 / count) for the lane counts 1 to 8.
   function automatic logic [RECIP_W-1:0] lane_recip(input logic [COUNT_W-1:0] count);
      logic [RECIP_W-1:0] recip;
      unique case (count)
         4'd1:    recip = 28'd134217728;
         4'd2:    recip = 28'd67108864;
         4'd3:    recip = 28'd44739242;
         4'd4:    recip = 28'd33554432;
         4'd5:    recip = 28'd26843545;
         4'd6:    recip = 28'd22369621;
         4'd7:    recip = 28'd19173961;
         4'd8:    recip = 28'd16777216;
         default: recip = '0;
      endcase
      return recip;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/dlr_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One channel of the incoming frame: captured on a transaction and gated to
// zero when the channel is not part of the down-mix.
module dlr_lane (
   input  wire logic                 clock,
   input  wire logic                 load,
   input  wire logic                 enable,
   input  wire dlr_pkg::sample_type  sample,
   output dlr_pkg::sample_type       masked
);
   import dlr_pkg::*;

   sample_type masked_ff;
   sample_type masked_in;

   always_comb begin
      masked_in = masked_ff;
      if (load) begin
         masked_in = enable ? sample : '0;
      end
   end

   always_ff @(posedge clock) begin
      masked_ff <= masked_in;
   end

   assign masked = masked_ff;

endmodule

`default_nettype wire

// ===== rtl/dlr_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Combines the lanes: a two-level registered adder tree, then the average by
// a reciprocal multiply and a one-step remainder correction, truncated toward
// zero.
module dlr_merge #(
   parameter int NUM_LANES = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire dlr_pkg::sample_type          lane_val [NUM_LANES],
   input  wire logic [dlr_pkg::COUNT_W-1:0]  lane_count,
   output logic                              mono_valid,
   output dlr_pkg::sample_type               mono
);
   import dlr_pkg::*;

   localparam int PAIRS  = LANE_FIELDS / 2;
   localparam int PROD_W = SUM_W + RECIP_W;

   sample_type padded [LANE_FIELDS];

   pair_type pair_ff [PAIRS];
   pair_type pair_in [PAIRS];
   sum_type  total_ff;
   sum_type  total_in;

   logic               neg_ff;
   logic               neg_in;
   logic [SUM_W-1:0]   mag_ff;
   logic [SUM_W-1:0]   mag_in;
   logic [SUM_W-1:0]   q0_ff;
   logic [SUM_W-1:0]   q0_in;
   logic [COUNT_W-1:0] div_ff;
   logic [PROD_W-1:0]  recip_prod;

   logic [SUM_W-1:0]   back_prod;
   logic [SUM_W-1:0]   remainder;
   logic [SUM_W-1:0]   quotient;
   sample_type         mono_ff;
   sample_type         mono_in;

   logic [3:0] valid_ff;
   logic [3:0] valid_in;

   for (genvar k = 0; k < LANE_FIELDS; k++) begin : g_pad
      if (k < NUM_LANES) begin : g_used
         assign padded[k] = lane_val[k];
      end else begin : g_unused
         assign padded[k] = '0;
      end
   end

   // First tree level: neighboring lanes.
   always_comb begin
      for (int j = 0; j < PAIRS; j++) begin
         pair_in[j] = pair_type'(padded[2*j]) + pair_type'(padded[2*j+1]);
      end
   end

   // Second tree level: the four pair sums.
   assign total_in = sum_type'(pair_ff[0]) + sum_type'(pair_ff[1])
                   + sum_type'(pair_ff[2]) + sum_type'(pair_ff[3]);

   // Divide the magnitude by the lane count; the estimate is low by at most one.
   always_comb begin
      neg_in     = total_ff[SUM_W-1];
      mag_in     = neg_in ? SUM_W'(-total_ff) : SUM_W'(total_ff);
      recip_prod = PROD_W'(mag_in) * PROD_W'(lane_recip(lane_count));
      q0_in      = recip_prod[RECIP_SHIFT +: SUM_W];
   end

   always_comb begin
      back_prod = q0_ff * SUM_W'(div_ff);
      remainder = mag_ff - back_prod;
      quotient  = q0_ff + SUM_W'(remainder >= SUM_W'(div_ff));
      mono_in   = neg_ff ? SAMPLE_W'(-quotient) : SAMPLE_W'(quotient);
   end

   assign valid_in = {valid_ff[2:0], in_valid};

   always_ff @(posedge clock) begin
      pair_ff  <= pair_in;
      total_ff <= total_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      q0_ff    <= q0_in;
      div_ff   <= lane_count;
      mono_ff  <= mono_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign mono_valid = valid_ff[3];
   assign mono       = mono_ff;

endmodule

`default_nettype wire

// ===== rtl/dlr_interp.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Four-stage interpolator: a + (b - a) * rem / OUT_RATE_HZ, truncated toward
// zero, clamped to +-1.0 and scaled to a 16-bit sample.
module dlr_interp #(
   parameter int OUT_RATE_HZ = 16000
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire dlr_pkg::sample_type               a,
   input  wire dlr_pkg::sample_type               b,
   input  wire logic [$clog2(OUT_RATE_HZ)-1:0]    rem,
   output logic                                   out_valid,
   output dlr_pkg::out_sample_type                out_sample
);
   import dlr_pkg::*;

   localparam int REM_W     = $clog2(OUT_RATE_HZ);
   localparam int FRAC_BITS = 26;
   localparam int MAG_W     = SAMPLE_W + 1;
   localparam int WPROD_W   = REM_W + FRAC_BITS + 1;
   localparam int QPROD_W   = MAG_W + FRAC_BITS;
   localparam int P_W       = MAG_W + REM_W;
   localparam int V_W       = MAG_W + 1;
   localparam int SCALE_W   = Q_FRAC + OUT_W;

   // floor(2**(FRAC_BITS+REM_W) / OUT_RATE_HZ); rem * RECIP >> REM_W is then
   // rem / OUT_RATE_HZ in units of 2**-FRAC_BITS, low by less than two.
   localparam logic [FRAC_BITS:0] RECIP =
      (FRAC_BITS+1)'((64'd1 << (FRAC_BITS + REM_W)) / 64'(OUT_RATE_HZ));
   localparam logic [P_W-1:0]     OUT_C = P_W'(OUT_RATE_HZ);
   localparam logic signed [V_W-1:0] Q_ONE_V = V_W'(1 << Q_FRAC);

   // Stage 1: difference and the fractional weight.
   logic signed [MAG_W-1:0] delta;
   logic [WPROD_W-1:0]      wprod;
   sample_type              s1_a_ff;
   logic                    s1_neg_ff;
   logic [MAG_W-1:0]        s1_mag_ff;
   logic [REM_W-1:0]        s1_rem_ff;
   logic [FRAC_BITS-1:0]    s1_w_ff;

   // Stage 2: quotient estimate and the exact product.
   logic [QPROD_W-1:0]      qprod;
   sample_type              s2_a_ff;
   logic                    s2_neg_ff;
   logic [MAG_W-1:0]        s2_q0_ff;
   logic [P_W-1:0]          s2_p_ff;

   // Stage 3: corrected quotient.
   logic [P_W-1:0]          s3_r;
   sample_type              s3_a_ff;
   logic                    s3_neg_ff;
   logic [MAG_W-1:0]        s3_q_ff;
   logic [MAG_W-1:0]        s3_q_in;

   // Stage 4: sum, clamp and scale.
   logic signed [V_W-1:0]   qs;
   logic signed [V_W-1:0]   v;
   logic signed [V_W-1:0]   vc;
   logic                    cneg;
   logic [V_W-1:0]          cmag_full;
   logic [Q_FRAC:0]         cmag;
   logic [SCALE_W-1:0]      scaled;
   logic [OUT_W-1:0]        smag;
   out_sample_type          out_ff;
   out_sample_type          out_in;

   logic [3:0] valid_ff;
   logic [3:0] valid_in;

   always_comb begin
      delta = MAG_W'(b) - MAG_W'(a);
      wprod = WPROD_W'(rem) * WPROD_W'(RECIP);
   end

   always_ff @(posedge clock) begin
      s1_a_ff   <= a;
      s1_neg_ff <= delta[MAG_W-1];
      s1_mag_ff <= delta[MAG_W-1] ? MAG_W'(-delta) : MAG_W'(delta);
      s1_rem_ff <= rem;
      s1_w_ff   <= wprod[REM_W +: FRAC_BITS];
   end

   assign qprod = QPROD_W'(s1_mag_ff) * QPROD_W'(s1_w_ff);

   always_ff @(posedge clock) begin
      s2_a_ff   <= s1_a_ff;
      s2_neg_ff <= s1_neg_ff;
      s2_q0_ff  <= qprod[FRAC_BITS +: MAG_W];
      s2_p_ff   <= P_W'(s1_mag_ff) * P_W'(s1_rem_ff);
   end

   always_comb begin
      s3_r    = s2_p_ff - P_W'(s2_q0_ff) * OUT_C;
      s3_q_in = s2_q0_ff + MAG_W'(s3_r >= OUT_C);
   end

   always_ff @(posedge clock) begin
      s3_a_ff   <= s2_a_ff;
      s3_neg_ff <= s2_neg_ff;
      s3_q_ff   <= s3_q_in;
   end

   always_comb begin
      qs = $signed({1'b0, s3_q_ff});
      v  = V_W'(s3_a_ff) + (s3_neg_ff ? -qs : qs);
      if (v > Q_ONE_V) begin
         vc = Q_ONE_V;
      end else if (v < -Q_ONE_V) begin
         vc = -Q_ONE_V;
      end else begin
         vc = v;
      end
      cneg      = vc[V_W-1];
      cmag_full = cneg ? V_W'(-vc) : V_W'(vc);
      cmag      = cmag_full[Q_FRAC:0];
      // Multiply by 2**15 - 1, then drop the Q2.22 fraction.
      scaled    = {cmag, (OUT_W-1)'(0)} - SCALE_W'(cmag);
      smag      = scaled[Q_FRAC +: OUT_W];
      out_in    = cneg ? OUT_W'(-smag) : OUT_W'(smag);
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign valid_in = {valid_ff[2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid  = valid_ff[3];
   assign out_sample = out_ff;

endmodule

`default_nettype wire

// ===== rtl/downmix_linear_resampler_16k.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tdata: lane0..lane7 samples; tlast: buffer_end
// rsp_      out        rsp_tvalid/rsp_tready  tdata: mono_sample; tlast: run_last;
//                                             tuser: buffer_done
// csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
// A frame yields at most 4 samples. Its averaging path (lane capture, two
// adder-tree levels, two divider stages) feeds the four-stage interpolator,
// which holds one output position at a time and starts a new sample only
// when the last one is through. Reset is synchronous and active high and
// restores channel_count to 2, input_rate_hz to 48000 and a clear phase. A
// finished sample waits in the output register while the next frame is
// taken; a further sample is started only once that register is free.
module downmix_linear_resampler_16k #(
   parameter int MAX_LANES   = 8,
   parameter int OUT_RATE_HZ = 16000
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // From bit 0 up: lane0_sample .. lane7_sample, 24 bits each.
   input  wire logic [dlr_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic                                req_tlast,

   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // From bit 0 up: mono_sample, 16 bits.
   output logic [dlr_pkg::OUT_W-1:0]                rsp_tdata,
   output logic                                     rsp_tlast,
   // From bit 0 up: buffer_done.
   output logic [0:0]                               rsp_tuser,

   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [dlr_pkg::CFG_ADDR_W-1:0]      csr_index,
   input  wire logic [dlr_pkg::CFG_DATA_W-1:0]      csr_data
);
   import dlr_pkg::*;

   // Lanes actually built: the frame never carries more than eight.
   localparam int NUM_LANES = (MAX_LANES < LANE_FIELDS) ? MAX_LANES : LANE_FIELDS;
   localparam int REM_W     = $clog2(OUT_RATE_HZ);
   // The position must hold a remainder plus the largest rate step.
   localparam int PW        = $clog2(2 * OUT_RATE_HZ + 192000);

   localparam logic [PW-1:0]      OUT_P       = PW'(OUT_RATE_HZ);
   localparam logic [PW-1:0]      OUT2_P      = PW'(2 * OUT_RATE_HZ);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(NUM_LANES);
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'((NUM_LANES < 2) ? NUM_LANES : 2);
   localparam logic [RATE_W-1:0]  RATE_RESET  = 18'd48000;
   localparam logic [CNT_W-1:0]   CAP         = CNT_W'(RESULT_CAP);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MONO = 2'd1;
   localparam logic [1:0] ST_PLAN = 2'd2;
   localparam logic [1:0] ST_WAIT = 2'd3;

   logic req_accept;
   logic out_free;

   // Configuration, stored already clamped to the usable range.
   logic [COUNT_W-1:0] lanes_ff;
   logic [COUNT_W-1:0] lanes_in;
   logic [RATE_W-1:0]  rate_ff;
   logic [RATE_W-1:0]  rate_in;
   logic [COUNT_W-1:0] count_wr;
   logic [RATE_W-1:0]  rate_wr;

   // Lanes and merge.
   logic [NUM_LANES-1:0] lane_en;
   sample_type           lane_val [NUM_LANES];
   logic                 lanes_valid_ff;
   logic                 mono_valid;
   sample_type           mono;

   // Sequencer and phase.
   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   logic [PW-1:0]     pos_ff;
   logic [PW-1:0]     pos_in;
   logic [PW-1:0]     pos_next;
   sample_type        prev_ff;
   sample_type        prev_in;
   sample_type        cur_ff;
   sample_type        cur_in;
   logic              have_prev_ff;
   logic              have_prev_in;
   logic              tail_ff;
   logic              tail_in;
   logic              last_ff;
   logic              last_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic              flag_last_ff;
   logic              flag_last_in;
   logic              flag_done_ff;
   logic              flag_done_in;
   logic              issue;
   logic              more_after;
   logic              run_last;

   // Interpolator.
   logic              interp_valid;
   out_sample_type    interp_sample;

   // Output register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [OUT_W-1:0]  rsp_data_ff;
   logic [OUT_W-1:0]  rsp_data_in;
   logic              rsp_last_ff;
   logic              rsp_last_in;
   logic              rsp_user_ff;
   logic              rsp_user_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Configuration writes. A channel count of zero acts as one, and counts
   // above the lanes present act as that maximum; the rate saturates.
   always_comb begin
      count_wr = csr_data[COUNT_W-1:0];
      if (count_wr == '0) begin
         count_wr = COUNT_W'(1);
      end else if (count_wr > COUNT_MAX) begin
         count_wr = COUNT_MAX;
      end
      rate_wr = csr_data[RATE_W-1:0];
      if (rate_wr < RATE_MIN) begin
         rate_wr = RATE_MIN;
      end else if (rate_wr > RATE_MAX) begin
         rate_wr = RATE_MAX;
      end
      lanes_in = lanes_ff;
      rate_in  = rate_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_CHANNEL_COUNT: lanes_in = count_wr;
            REG_INPUT_RATE:    rate_in  = rate_wr;
            default: begin
            end
         endcase
      end
   end

   // Each lane captures its channel on the input transaction.
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      assign lane_en[k] = COUNT_W'(k) < lanes_ff;

      dlr_lane u_lane (
         .clock  (clock),
         .load   (req_accept),
         .enable (lane_en[k]),
         .sample (req_tdata[k*SAMPLE_W +: SAMPLE_W]),
         .masked (lane_val[k])
      );
   end

   dlr_merge #(
      .NUM_LANES (NUM_LANES)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (lanes_valid_ff),
      .lane_val   (lane_val),
      .lane_count (lanes_ff),
      .mono_valid (mono_valid),
      .mono       (mono)
   );

   // The output position is kept as pos = offset * OUT_RATE_HZ + remainder,
   // where offset counts frames past the latest one. A position interpolates
   // the current pair of frames while pos is below one frame. At a buffer's
   // end the current frame is paired with itself until pos passes it.
   assign pos_next   = pos_ff + PW'(rate_ff);
   assign more_after = !tail_ff && last_ff && (pos_next < OUT2_P);
   assign run_last   = ((pos_next >= OUT_P) && !more_after) || (cnt_ff == CAP - CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      have_prev_in = have_prev_ff;
      tail_in      = tail_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      flag_last_in = flag_last_ff;
      flag_done_in = flag_done_ff;
      issue        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               last_in  = req_tlast;
               cnt_in   = '0;
               state_in = ST_MONO;
            end
         end
         ST_MONO: begin
            if (mono_valid) begin
               cur_in = mono;
               if (have_prev_ff) begin
                  tail_in = 1'b0;
               end else begin
                  // First frame of a buffer: nothing to pair with yet.
                  have_prev_in = 1'b1;
                  tail_in      = 1'b1;
               end
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            if ((pos_ff < OUT_P) && (!tail_ff || last_ff)) begin
               if (cnt_ff < CAP) begin
                  if (out_free) begin
                     issue        = 1'b1;
                     pos_in       = pos_next;
                     cnt_in       = cnt_ff + CNT_W'(1);
                     flag_last_in = run_last;
                     flag_done_in = run_last && last_ff;
                     state_in     = ST_WAIT;
                  end
               end else begin
                  // Beyond the per-frame limit: the phase still moves on.
                  pos_in = pos_next;
               end
            end else if (!tail_ff) begin
               pos_in  = pos_ff - OUT_P;
               tail_in = 1'b1;
            end else begin
               if (last_ff) begin
                  prev_in      = '0;
                  have_prev_in = 1'b0;
                  pos_in       = '0;
               end else begin
                  prev_in = cur_ff;
               end
               state_in = ST_IDLE;
            end
         end
         ST_WAIT: begin
            if (interp_valid) begin
               state_in = ST_PLAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   dlr_interp #(
      .OUT_RATE_HZ (OUT_RATE_HZ)
   ) u_interp (
      .clock      (clock),
      .reset      (reset),
      .start      (issue),
      .a          (tail_ff ? cur_ff : prev_ff),
      .b          (cur_ff),
      .rem        (pos_ff[REM_W-1:0]),
      .out_valid  (interp_valid),
      .out_sample (interp_sample)
   );

   // Output register. A sample is started only when this register will be
   // free, so an arriving sample always finds it empty.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      if (interp_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = interp_sample;
         rsp_last_in  = flag_last_ff;
         rsp_user_in  = flag_done_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         lanes_ff       <= COUNT_RESET;
         rate_ff        <= RATE_RESET;
         pos_ff         <= '0;
         prev_ff        <= '0;
         have_prev_ff   <= 1'b0;
         tail_ff        <= 1'b0;
         last_ff        <= 1'b0;
         cnt_ff         <= '0;
         lanes_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         lanes_ff       <= lanes_in;
         rate_ff        <= rate_in;
         pos_ff         <= pos_in;
         prev_ff        <= prev_in;
         have_prev_ff   <= have_prev_in;
         tail_ff        <= tail_in;
         last_ff        <= last_in;
         cnt_ff         <= cnt_in;
         lanes_valid_ff <= req_accept;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      flag_last_ff <= flag_last_in;
      flag_done_ff <= flag_done_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_user_ff;

`ifndef ASSERT_OFF
   // A finished sample must never overwrite one that has not been taken.
   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      interp_valid |-> !rsp_valid_ff)
      else $error("interpolator result arrived while the output register was full");

   // The averaged frame only returns while the sequencer waits for it.
   a_mono_in_state: assert property (@(posedge clock) disable iff (reset)
      mono_valid |-> (state_ff == ST_MONO))
      else $error("mono value arrived outside the averaging wait");

   // The end-of-buffer flag only rides on the last sample of a frame.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |-> rsp_last_ff)
      else $error("buffer_done without run_last");

   // Between buffers the phase is back at zero.
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) && !have_prev_ff) |-> (pos_ff == '0))
      else $error("phase not restarted between buffers");
`endif

endmodule

`default_nettype wire
